FILE: design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg - shared types and constants for the barometric compensation unit
// Register indexes, sequencer states, scaling constants and the result record.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_T1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P23 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P45 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P67 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_P89 = 3'd7;

  localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
  localparam logic [63:0] P_FULL_SCALE = 64'd1048576;
  localparam logic [63:0] P_SCALE = 64'd3125;
  localparam logic [31:0] T_ROUND = 32'd128;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CNT_W = 7;

  // Sequencer steps; multiplier operands are chosen per step.
  typedef enum logic [4:0] {
    S_IDLE,
    S_T_D1,      // d1*t2
    S_T_D2SQ,    // d2*d2
    S_T_V2,      // (d2sq>>>12)*t3
    S_T_FIN,     // t_fine*5
    S_P_AA,      // a*a
    S_P_B6,      // aa*p6
    S_P_B5,      // a*p5
    S_P_A3,      // aa*p3
    S_P_A2,      // a*p2
    S_P_A1,      // (2^47+a)*p1
    S_P_CHK,
    S_P_NUM,     // numerator*3125
    S_P_DIV,
    S_P_DSGN,
    S_P_C1,      // p9*(p>>>13)
    S_P_C2,      // *(p>>>13)
    S_P_D,       // p8*p
    S_P_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] temp;
    logic [31:0] pres;
    logic        zdiv;
  } result_t;

endpackage

FILE: design/bsc_mul.sv
// ----------------------------------------------------------------------------
// bsc_mul - shared 64x64 wrap multiplier, three 32x32 partial products
// One partial product per cycle; done pulses with the low 64 bits.
// ----------------------------------------------------------------------------
module bsc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] ra, rb, acc;
  logic [2:0]  step;
  logic        busy;
  logic [31:0] opa, opb;
  logic [63:0] pp;

  always_comb begin
    case (step[1:0])
      2'd0: begin opa = ra[31:0]; opb = rb[31:0]; end
      2'd1: begin opa = ra[63:32]; opb = rb[31:0]; end
      2'd2: begin opa = ra[31:0]; opb = rb[63:32]; end
      default: begin opa = 32'd0; opb = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    pp <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        ra   <= a;
        rb   <= b;
        acc  <= 64'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        // pp holds the product of the previous step
        case (step)
          3'd1: acc <= pp;
          3'd2: acc <= acc + {pp[31:0], 32'd0};
          3'd3: begin
            acc  <= acc + {pp[31:0], 32'd0};
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: acc <= acc;
        endcase
      end
    end
  end

  assign prod = acc;

endmodule

FILE: design/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div - 64-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [63:0] rem, q, d;
  logic [bsc_pkg::DIV_CNT_W-1:0] cnt;
  logic busy;
  logic [64:0] trial;

  assign trial = {rem, q[63]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= 64'd0;
        q    <= num;
        d    <= den;
        cnt  <= '0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == bsc_pkg::DIV_CNT_W'(bsc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;

endmodule

FILE: design/barometric_sample_compensation_unit.sv
// ----------------------------------------------------------------------------
// barometric_sample_compensation_unit - temperature and pressure compensation
// Temperature takes four 64-bit multiplies on the shared multiplier and an output
// step; pressure takes ten multiplies, a divide and four single-state steps (check,
// sign, final, output), or six multiplies, the check and the output step when the
// divisor is zero.
// One beat at a time: s_tready is high only in idle, so a new beat is taken only
// after the last one has left its output step.
// A result held by m_tready low stalls the next one in its output step.
// Reset (rst, synchronous): coefficients and fine temperature clear to zero.
// ----------------------------------------------------------------------------
module barometric_sample_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] raw_sample
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] temperature_centi, [63:32] pressure_q24_8,
                                 // [64] zero_divisor
  output logic        m_tuser    // [0] result_kind
);

  // calibration
  logic [15:0] t1, t2, t3, p1;
  logic [31:0] p23, p45, p67, p89;
  logic [31:0] fine_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0; t2 <= '0; t3 <= '0; p1 <= '0;
      p23 <= '0; p45 <= '0; p67 <= '0; p89 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsc_pkg::REG_T1:  t1 <= cfg_data[15:0];
        bsc_pkg::REG_T2:  t2 <= cfg_data[15:0];
        bsc_pkg::REG_T3:  t3 <= cfg_data[15:0];
        bsc_pkg::REG_P1:  p1 <= cfg_data[15:0];
        bsc_pkg::REG_P23: p23 <= cfg_data;
        bsc_pkg::REG_P45: p45 <= cfg_data;
        bsc_pkg::REG_P67: p67 <= cfg_data;
        bsc_pkg::REG_P89: p89 <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  bsc_pkg::state_t state, state_next;
  logic        kind;
  logic [19:0] adc;
  // working registers: a = offset fine temp, then divisor, b, aa, x = scratch, p = pressure
  logic [63:0] a, b, aa, x, p;
  logic        mstart, mdone, dstart, ddone, mwait;
  logic [63:0] ma, mb, prod, dnum, dden, quo;
  logic        neg_q;
  bsc_pkg::result_t res;

  bsc_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod);
  bsc_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(dden), .done(ddone),
                 .quo);

  logic [31:0] d1, d2;
  assign d1 = {15'd0, adc[19:3]} - {15'd0, t1, 1'b0};
  assign d2 = {16'd0, adc[19:4]} - {16'd0, t1};

  logic [63:0] ps13;
  assign ps13 = $signed(p) >>> 13;

  // multiplier operands per step
  always_comb begin
    ma = 64'd0; mb = 64'd0;
    case (state)
      bsc_pkg::S_T_D1:   begin ma = {32'd0, d1}; mb = sx16(t2); end
      bsc_pkg::S_T_D2SQ: begin ma = {32'd0, d2}; mb = {32'd0, d2}; end
      bsc_pkg::S_T_V2:   begin
        ma = {32'd0, 32'($signed(x[31:0]) >>> 12)}; mb = sx16(t3);
      end
      bsc_pkg::S_T_FIN:  begin ma = {32'd0, fine_t}; mb = 64'd5; end
      bsc_pkg::S_P_AA:   begin ma = a; mb = a; end
      bsc_pkg::S_P_B6:   begin ma = aa; mb = sx16(p67[15:0]); end
      bsc_pkg::S_P_B5:   begin ma = a; mb = sx16(p45[31:16]); end
      bsc_pkg::S_P_A3:   begin ma = aa; mb = sx16(p23[31:16]); end
      bsc_pkg::S_P_A2:   begin ma = a; mb = sx16(p23[15:0]); end
      bsc_pkg::S_P_A1:   begin ma = (64'd1 << 47) + x; mb = {48'd0, p1}; end
      bsc_pkg::S_P_NUM:  begin ma = x; mb = bsc_pkg::P_SCALE; end
      bsc_pkg::S_P_C1:   begin ma = sx16(p89[31:16]); mb = ps13; end
      bsc_pkg::S_P_C2:   begin ma = x; mb = ps13; end
      bsc_pkg::S_P_D:    begin ma = sx16(p89[15:0]); mb = p; end
      default: ;
    endcase
  end

  assign s_tready = (state == bsc_pkg::S_IDLE);
  assign dnum = x[63] ? -x : x;
  assign dden = a[63] ? -a : a;

  always_comb begin
    state_next = state;
    mstart = 1'b0;
    dstart = 1'b0;
    case (state)
      bsc_pkg::S_IDLE:
        if (s_tvalid) state_next = s_tuser ? bsc_pkg::S_P_AA : bsc_pkg::S_T_D1;
      bsc_pkg::S_P_CHK:
        state_next = (a == 64'd0) ? bsc_pkg::S_OUT : bsc_pkg::S_P_NUM;
      bsc_pkg::S_P_DIV: begin
        dstart = !mwait;
        if (ddone) state_next = bsc_pkg::S_P_DSGN;
      end
      bsc_pkg::S_P_DSGN: state_next = bsc_pkg::S_P_C1;
      bsc_pkg::S_P_FIN:  state_next = bsc_pkg::S_OUT;
      bsc_pkg::S_OUT:    if (!m_tvalid || m_tready) state_next = bsc_pkg::S_IDLE;
      default: begin
        mstart = !mwait;
        if (mdone) begin
          case (state)
            bsc_pkg::S_T_D1:   state_next = bsc_pkg::S_T_D2SQ;
            bsc_pkg::S_T_D2SQ: state_next = bsc_pkg::S_T_V2;
            bsc_pkg::S_T_V2:   state_next = bsc_pkg::S_T_FIN;
            bsc_pkg::S_T_FIN:  state_next = bsc_pkg::S_OUT;
            bsc_pkg::S_P_AA:   state_next = bsc_pkg::S_P_B6;
            bsc_pkg::S_P_B6:   state_next = bsc_pkg::S_P_B5;
            bsc_pkg::S_P_B5:   state_next = bsc_pkg::S_P_A3;
            bsc_pkg::S_P_A3:   state_next = bsc_pkg::S_P_A2;
            bsc_pkg::S_P_A2:   state_next = bsc_pkg::S_P_A1;
            bsc_pkg::S_P_A1:   state_next = bsc_pkg::S_P_CHK;
            bsc_pkg::S_P_NUM:  state_next = bsc_pkg::S_P_DIV;
            bsc_pkg::S_P_C1:   state_next = bsc_pkg::S_P_C2;
            bsc_pkg::S_P_C2:   state_next = bsc_pkg::S_P_D;
            default:           state_next = bsc_pkg::S_P_FIN;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bsc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // mwait: unit already launched for the current step
  always_ff @(posedge clk) begin
    if (rst) mwait <= 1'b0;
    else if (state_next != state) mwait <= 1'b0;
    else if (mstart || dstart) mwait <= 1'b1;
  end

  // output beat valid: set from the output step, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == bsc_pkg::S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  logic [63:0] pclamp;
  assign pclamp = 64'($signed(p + b + x) >>> 8) + (sx16(p67[31:16]) << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_t   <= '0;
    end else begin
      case (state)
        bsc_pkg::S_IDLE: if (s_tvalid) begin
          kind <= s_tuser;
          adc  <= s_tdata[19:0];
          a    <= {{32{fine_t[31]}}, fine_t} - bsc_pkg::T_FINE_OFFSET;
          res  <= '0;
        end
        bsc_pkg::S_T_D1:   if (mdone) b <= {32'd0, 32'($signed(prod[31:0]) >>> 11)};
        bsc_pkg::S_T_D2SQ: if (mdone) x <= prod;
        bsc_pkg::S_T_V2:   if (mdone)
          fine_t <= b[31:0] + 32'($signed(prod[31:0]) >>> 14);
        bsc_pkg::S_T_FIN:  if (mdone)
          res.temp <= 32'($signed(prod[31:0] + bsc_pkg::T_ROUND) >>> 8);
        bsc_pkg::S_P_AA:   if (mdone) aa <= prod;
        bsc_pkg::S_P_B6:   if (mdone) b <= prod + (sx16(p45[15:0]) << 35);
        bsc_pkg::S_P_B5:   if (mdone) b <= b + (prod << 17);
        bsc_pkg::S_P_A3:   if (mdone) x <= $signed(prod) >>> 8;
        bsc_pkg::S_P_A2:   if (mdone) x <= x + (prod << 12);
        bsc_pkg::S_P_A1:   if (mdone) begin
          a <= $signed(prod) >>> 33;
          x <= ((bsc_pkg::P_FULL_SCALE - {44'd0, adc}) << 31) - b;
        end
        bsc_pkg::S_P_CHK: if (a == 64'd0) res.zdiv <= 1'b1;
        bsc_pkg::S_P_NUM:  if (mdone) x <= prod;
        bsc_pkg::S_P_DIV:  neg_q <= x[63] ^ a[63];
        bsc_pkg::S_P_DSGN: p <= neg_q ? -quo : quo;
        bsc_pkg::S_P_C1:   if (mdone) x <= prod;
        bsc_pkg::S_P_C2:   if (mdone) b <= $signed(prod) >>> 25;
        bsc_pkg::S_P_D:    if (mdone) x <= $signed(prod) >>> 19;
        bsc_pkg::S_P_FIN: begin
          if (pclamp[63]) res.pres <= 32'd0;
          else if (pclamp[63:32] != 32'd0) res.pres <= 32'hFFFF_FFFF;
          else res.pres <= pclamp[31:0];
        end
        bsc_pkg::S_OUT: if (!m_tvalid || m_tready) begin
          m_tuser  <= kind;
          m_tdata  <= {7'd0, res.zdiv, res.pres, res.temp};
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb_barometric_sample_compensation_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_barometric_sample_compensation_unit - self-checking bench
// Drives temperature and pressure samples under several calibration sets,
// predicts every result beat in 32/64-bit wrap arithmetic and compares it
// field by field with the output stream. Both sides idle at random in all but one phase.
// ----------------------------------------------------------------------------
module tb_barometric_sample_compensation_unit;

  typedef struct packed {
    logic        kind;
    logic [19:0] raw;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;

  // Calibration shadow and stored fine temperature
  logic [31:0] cal [8];
  logic [31:0] fine_t;

  sample_t          pending_samples[$];
  bsc_pkg::result_t expected_results[$];
  int      mismatches = 0;
  bit      idle_on = 1'b1;   // random idling enabled
  bit      in_taken = 1'b0;  // beat on the input was accepted at the last edge

  barometric_sample_compensation_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sdiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  // Compensates one sample; updates the fine temperature on temperature beats.
  function automatic bsc_pkg::result_t compensate(input sample_t smp);
    bsc_pkg::result_t r;
    logic signed [31:0] d1, d2, v1, v2, t2, t3;
    logic signed [63:0] a, b, p, c, d, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    r = '0;
    r.kind = smp.kind;
    if (!smp.kind) begin
      t2 = 32'(signed'(cal[bsc_pkg::REG_T2][15:0]));
      t3 = 32'(signed'(cal[bsc_pkg::REG_T3][15:0]));
      d1 = {15'd0, smp.raw[19:3]} - {15'd0, cal[bsc_pkg::REG_T1][15:0], 1'b0};
      d2 = {16'd0, smp.raw[19:4]} - {16'd0, cal[bsc_pkg::REG_T1][15:0]};
      v1 = (d1 * t2) >>> 11;
      v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      fine_t = v1 + v2;
      r.temp = (signed'(fine_t) * 32'sd5 + 32'sd128) >>> 8;
    end else begin
      p1 = {48'd0, cal[bsc_pkg::REG_P1][15:0]};
      p2 = sx16(cal[bsc_pkg::REG_P23][15:0]);  p3 = sx16(cal[bsc_pkg::REG_P23][31:16]);
      p4 = sx16(cal[bsc_pkg::REG_P45][15:0]);  p5 = sx16(cal[bsc_pkg::REG_P45][31:16]);
      p6 = sx16(cal[bsc_pkg::REG_P67][15:0]);  p7 = sx16(cal[bsc_pkg::REG_P67][31:16]);
      p8 = sx16(cal[bsc_pkg::REG_P89][15:0]);  p9 = sx16(cal[bsc_pkg::REG_P89][31:16]);
      a = 64'(signed'(fine_t)) - 64'sd128000;
      b = a * a * p6;
      b += (a * p5) <<< 17;
      b += p4 <<< 35;
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      if (a == 0) begin
        r.zdiv = 1'b1;
      end else begin
        p = 64'sd1048576 - 64'(smp.raw);
        p = sdiv(((p <<< 31) - b) * 64'sd3125, a);
        c = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        d = (p8 * p) >>> 19;
        p = ((p + c + d) >>> 8) + (p7 <<< 4);
        if (p < 0) r.pres = '0;
        else if (p > 64'sh0FFFFFFFF) r.pres = '1;
        else r.pres = p[31:0];
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued samples; predicts on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(compensate(sample_t'({s_tuser, s_tdata[19:0]})));
    end
  end

  always @(negedge clk) begin
    sample_t next_smp;
    if (rst || (s_tvalid && !in_taken)) begin
      // hold the current beat until it is taken
    end else if (pending_samples.size() > 0 && !(idle_on && $urandom_range(99) < 17)) begin
      next_smp = pending_samples.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= {4'd0, next_smp.raw};
      s_tuser  <= next_smp.kind;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: output backpressure and field checks
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    m_tready <= !rst && !(idle_on && $urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    bsc_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report("unexpected beat", m_tdata[63:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser != want.kind)
          report("result_kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[31:0] != want.temp)
          report("temperature_centi", 64'(m_tdata[31:0]), 64'(want.temp));
        if (m_tdata[63:32] != want.pres)
          report("pressure_q24_8", 64'(m_tdata[63:32]), 64'(want.pres));
        if (m_tdata[64] != want.zdiv)
          report("zero_divisor", 64'(m_tdata[64]), 64'(want.zdiv));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic drain();
    while (pending_samples.size() > 0 || expected_results.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cal[idx]  = (idx < bsc_pkg::REG_P23) ? {16'd0, val[15:0]} : val;
  endtask

  task automatic queue_sample(input logic kind, input logic [19:0] raw);
    sample_t s;
    s.kind = kind;
    s.raw  = raw;
    pending_samples.push_back(s);
  endtask

  // Datasheet-like calibration with optional random jitter
  task automatic load_typical(input bit jitter);
    logic [31:0] j;
    j = jitter ? $urandom_range(255) : 0;
    write_reg(bsc_pkg::REG_T1, 27504 + j);
    write_reg(bsc_pkg::REG_T2, 26435 - j);
    write_reg(bsc_pkg::REG_T3, 32'hFC18);
    write_reg(bsc_pkg::REG_P1, 36477 + j);
    write_reg(bsc_pkg::REG_P23, {16'd3024, 16'hD5D4});
    write_reg(bsc_pkg::REG_P45, {16'hFF74, 16'd2855 + 16'(j)});
    write_reg(bsc_pkg::REG_P67, {16'd15500, 16'hFFF9});
    write_reg(bsc_pkg::REG_P89, {16'd6000, 16'hC0F8});
  endtask

  task automatic random_regs();
    for (int i = 0; i < 8; i++) write_reg(3'(i), $urandom());
  endtask

  initial begin
    for (int i = 0; i < 8; i++) cal[i] = '0;
    fine_t = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Pressure before any temperature, all-zero calibration: zero divisor
    queue_sample(1'b1, 20'd0);
    queue_sample(1'b0, 20'hFFFFF);
    queue_sample(1'b1, 20'hFFFFF);
    drain();

    // Typical calibration, field extremes
    load_typical(1'b0);
    queue_sample(1'b1, 20'h65000);   // pressure using stale fine temperature
    queue_sample(1'b0, 20'd519888);
    queue_sample(1'b1, 20'd415148);
    queue_sample(1'b0, 20'd0);
    queue_sample(1'b1, 20'd0);
    queue_sample(1'b0, 20'hFFFFF);
    queue_sample(1'b1, 20'hFFFFF);
    queue_sample(1'b1, 20'h55555);
    queue_sample(1'b0, 20'hAAAAA);
    drain();

    // Extreme calibration words: temperature wrap, clamp at both ends
    write_reg(bsc_pkg::REG_T1, 32'hFFFF);
    write_reg(bsc_pkg::REG_T2, 32'h8000);
    write_reg(bsc_pkg::REG_T3, 32'h7FFF);
    write_reg(bsc_pkg::REG_P1, 32'hFFFF);
    write_reg(bsc_pkg::REG_P23, 32'h7FFF8000);
    write_reg(bsc_pkg::REG_P45, 32'h80007FFF);
    write_reg(bsc_pkg::REG_P67, 32'h7FFF7FFF);
    write_reg(bsc_pkg::REG_P89, 32'h80008000);
    queue_sample(1'b0, 20'd0);
    queue_sample(1'b1, 20'd0);
    queue_sample(1'b1, 20'hFFFFF);
    queue_sample(1'b0, 20'hFFFFF);
    queue_sample(1'b1, 20'h80000);
    drain();
    write_reg(bsc_pkg::REG_P67, 32'h80008000);
    write_reg(bsc_pkg::REG_P89, 32'h7FFF7FFF);
    queue_sample(1'b1, 20'd1);
    queue_sample(1'b1, 20'hFFFFE);
    drain();

    // Random phases; calibration mostly typical, some fully random
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) random_regs();
      else load_typical(1'b1);
      idle_on = (ph != 4);   // one phase runs without idling
      for (int n = 0; n < 68; n++) begin
        if ($urandom_range(3) == 0)
          queue_sample(1'($urandom_range(1)), 20'($urandom()));
        else
          queue_sample(1'($urandom_range(1)), 20'($urandom_range(600000, 250000)));
      end
      drain();
    end
    idle_on = 1'b1;

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: bounds the run of ~700 items
  initial begin
    #(4 * 1000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
